[hdl/linear_interp_downsampler_defines.svh]
// Assertion macros for the linear interpolation down-sampler checker.
// No dependencies; included by the checker file only.
`ifndef LINEAR_INTERP_DOWNSAMPLER_DEFINES_SVH
`define LINEAR_INTERP_DOWNSAMPLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LID_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while the given reset term is high.
`define LID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lid_pkg.sv]
// Shared types and fixed constants for the linear interpolation down-sampler.
// No dependencies; imported by the top level and its checker.
package lid_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RATE_W   = 18;
  localparam int PHASE_W  = 18;
  // Phase arithmetic width: holds phase minus twice the largest source rate
  localparam int CALC_W   = 20;
  // Quotient width: magnitude reaches 32768 before saturation
  localparam int QUOT_W   = 17;
  // Fraction bits dropped from the phase to form a weight
  localparam int FRAC_W   = 8;

  localparam logic [RATE_W-1:0] TARGET_RESET = 18'd44100;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [RATE_W-1:0]   rate_t;
  typedef logic signed [PHASE_W-1:0]  phase_t;
  typedef logic signed [CALC_W-1:0]   calc_t;

endpackage

[hdl/linear_interp_downsampler.sv]
// Top level of the linear interpolation down-sampler.
// Depends on lid_pkg for sample, rate and phase types.
//
// Usage:
//   Input channel (in_valid / in_stall / source_sample) takes one source
//   sample per beat. Output channel (out_valid / out_stall / out_sample)
//   gives zero or one sample per input beat. Config channel (cfg_valid /
//   cfg_ready / cfg_data) writes target_rate; cfg_ready is always high and
//   writes are expected only while the block is idle.
//   Throughput: one input beat per cycle while in_stall is low. The phase update
//   and sample shift finish at the accept edge, which also loads the capture
//   stage; the two weight multiplies and then the reciprocal multiply for the
//   constant divide follow, and sign restore and saturation feed the output
//   register, where out_valid rises.
//   A stalled output holds its sample; stages behind it keep filling until
//   the chain is full, and only then is in_stall raised.
//   Reset: target_rate returns to 44100, phase, samples and the pending
//   flag clear, all pipeline stages empty. No clearing pass is needed.
module linear_interp_downsampler
  import lid_pkg::*;
#(
  parameter int unsigned SOURCE_RATE = 49715
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sample_t             source_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output sample_t             out_sample,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  rate_t               cfg_data
);

  // Constant divide by SOURCE_RATE/256 through an exact reciprocal multiply
  localparam int DIV    = SOURCE_RATE / 256;
  localparam int LOG_D  = $clog2(DIV);
  localparam int WGT_W  = $clog2(DIV + 1);
  localparam int PROD_W = SAMPLE_W + WGT_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int MAG_W  = SAMPLE_W + LOG_D;
  localparam int SHIFT  = MAG_W + LOG_D;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [MAG_W:0] RECIP = RECIP_WIDE[MAG_W:0];
  localparam rate_t SRC_RATE = RATE_W'(SOURCE_RATE);
  localparam calc_t SRC_CALC = CALC_W'(SOURCE_RATE);

  // Configuration and converter state
  rate_t   target_rate;
  phase_t  phase;
  sample_t older_sample;
  sample_t newer_sample;
  logic    second_pending;

  // Stage enables
  logic en1, en2, en3, en_out;
  logic in_accept;

  // Stage 1: snapshot of the updated state
  logic    v1;
  logic    s1_pass;
  sample_t s1_old;
  sample_t s1_new;
  phase_t  s1_phase;

  // Stage 2: weighted products
  logic                     v2;
  logic                     s2_pass;
  sample_t                  s2_samp;
  logic signed [PROD_W-1:0] s2_pa;
  logic signed [PROD_W-1:0] s2_pb;

  // Stage 3: quotient magnitude and sign
  logic              v3;
  logic              s3_pass;
  sample_t           s3_samp;
  logic              s3_neg;
  logic [QUOT_W-1:0] s3_quot;

  // Phase update logic
  logic    passthru;
  calc_t   phase_ext;
  calc_t   rate_ext;
  calc_t   p_first;
  calc_t   p_second;
  phase_t  phase_next;
  logic    pending_next;
  logic    fire;

  assign cfg_ready = 1'b1;

  // Advance each stage when it is empty or the one ahead moves
  assign en_out    = !out_valid || !out_stall;
  assign en3       = !v3 || en_out;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign in_stall  = !en1;
  assign in_accept = in_valid && en1;

  // Lower the phase, add the target back when it goes negative
  always_comb begin
    passthru  = (target_rate >= SRC_RATE);
    phase_ext = CALC_W'(phase);
    rate_ext  = calc_t'({{(CALC_W-RATE_W){1'b0}}, target_rate});
    p_first   = second_pending ? phase_ext : (phase_ext - SRC_CALC + rate_ext);
    p_second  = p_first + rate_ext;
    if (p_first[CALC_W-1]) begin
      phase_next   = p_second[PHASE_W-1:0];
      fire         = second_pending && !p_second[CALC_W-1];
      pending_next = !fire;
    end else begin
      phase_next   = p_first[PHASE_W-1:0];
      fire         = 1'b1;
      pending_next = 1'b0;
    end
  end

  // Hold the rate register, written by the config beat
  always_ff @(posedge clk) begin
    if (rst) begin
      target_rate <= TARGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      target_rate <= cfg_data;
    end
  end

  // Update phase and shift the sample pair on each converted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= '0;
      older_sample   <= '0;
      newer_sample   <= '0;
      second_pending <= 1'b0;
    end else if (in_accept && !passthru) begin
      phase          <= phase_next;
      older_sample   <= newer_sample;
      newer_sample   <= source_sample;
      second_pending <= pending_next;
    end
  end

  // Stage 1: capture the state that the result is built from
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_accept && (passthru || fire);
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_pass  <= passthru;
      s1_old   <= newer_sample;
      s1_new   <= source_sample;
      s1_phase <= phase_next;
    end
  end

  // Stage 2: weight both samples; phase is non-negative on a due output
  logic [WGT_W-1:0]  w_old;
  logic [WGT_W-1:0]  w_new;
  logic [PHASE_W-1:0] phase_rest;

  always_comb begin
    phase_rest = SRC_RATE - PHASE_W'(s1_phase);
    w_old      = WGT_W'(s1_phase[PHASE_W-1:FRAC_W]);
    w_new      = WGT_W'(phase_rest[PHASE_W-1:FRAC_W]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_pass <= s1_pass;
      s2_samp <= s1_new;
      s2_pa   <= PROD_W'(s1_old) * PROD_W'($signed({1'b0, w_old}));
      s2_pb   <= PROD_W'(s1_new) * PROD_W'($signed({1'b0, w_new}));
    end
  end

  // Stage 3: sum, take magnitude, divide by reciprocal multiply
  logic signed [SUM_W-1:0] sum;
  logic        [SUM_W-1:0] sum_abs;
  logic        [MAG_W-1:0] mag;
  logic        [2*MAG_W:0] quot_prod;

  always_comb begin
    sum       = SUM_W'(s2_pa) + SUM_W'(s2_pb);
    sum_abs   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    mag       = sum_abs[MAG_W-1:0];
    quot_prod = {{(MAG_W+1){1'b0}}, mag} * {{MAG_W{1'b0}}, RECIP};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_pass <= s2_pass;
      s3_samp <= s2_samp;
      s3_neg  <= sum[SUM_W-1];
      s3_quot <= quot_prod[SHIFT +: QUOT_W];
    end
  end

  // Output register: pass the sample through, or restore sign and saturate
  logic [QUOT_W-1:0] quot_neg;
  sample_t           result;

  always_comb begin
    quot_neg = QUOT_W'(-s3_quot);
    if (s3_pass) begin
      result = s3_samp;
    end else if (s3_neg) begin
      result = quot_neg[SAMPLE_W-1:0];
    end else if (s3_quot[QUOT_W-1]) begin
      result = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      result = s3_quot[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_sample <= result;
    end
  end

endmodule

[hdl/lid_checker.sv]
// Port-level checker for the linear interpolation down-sampler, with its bind.
// Depends on lid_pkg and the macros in linear_interp_downsampler_defines.svh.
`include "linear_interp_downsampler_defines.svh"

module lid_checker
  import lid_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    in_stall,
  input logic    out_valid,
  input logic    out_stall,
  input sample_t out_sample,
  input logic    cfg_valid,
  input logic    cfg_ready
);

  // A stalled output beat keeps its data
  `LID_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_sample), "stalled output beat changed")

  // Reset empties the output register
  `LID_ASSERT_NEXT(a_rst_empty, clk, 1'b0, rst, !out_valid, "output valid after reset")

  // A free output register lets the input through
  `LID_ASSERT_NOW(a_no_false_stall, clk, rst, !out_valid || !out_stall, !in_stall, "input stalled while output is free")

  // The config channel never blocks a write
  `LID_ASSERT_NOW(a_cfg_open, clk, rst, cfg_valid, cfg_ready, "config write not taken")

endmodule

bind linear_interp_downsampler lid_checker u_lid_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_sample    (out_sample),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);

[dv/linear_interp_downsampler_test.sv]
// Self-checking testbench for the linear interpolation down-sampler.
// A predictor runs in step with the input beats, and each output beat is checked
// against it in order. Depends on lid_pkg and the linear_interp_downsampler RTL.
module linear_interp_downsampler_test
  import lid_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SRC_RATE   = 49715;
  localparam int HALF_CLK   = 10;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_WAIT = 8;
  localparam int HOLD_LEN   = 80;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t source_sample = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sample_t out_sample;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  rate_t   cfg_data = '0;

  // Predictor state
  rate_t   rate_cfg;
  int      ph_acc;
  int      prev_smp;
  int      last_smp;
  bit      need_read;

  sample_t due_samples[$];
  int      mismatches = 0;
  int      idle_cycles = 0;

  // Receiver control: requests set by the tests, counters kept by the stall driver
  bit      hold_req = 1'b0;
  bit      quiet = 1'b0;
  int      hold_left = 0;
  int      busy_left = 0;
  int      free_left = 0;

  linear_interp_downsampler #(
    .SOURCE_RATE(SRC_RATE)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .source_sample(source_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sample   (out_sample),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #HALF_CLK clk = ~clk;

  // Advance the resampler by one source sample; returns 1 when an output is due
  function automatic bit resample(input sample_t s, output sample_t y);
    longint w_old;
    longint w_new;
    longint acc;
    y = '0;
    // Rate at or above the source rate: pass through, leave state alone
    if (int'(rate_cfg) >= SRC_RATE) begin
      y = s;
      return 1'b1;
    end
    if (!need_read) ph_acc = ph_acc - (SRC_RATE - int'(rate_cfg));
    prev_smp = last_smp;
    last_smp = int'(s);
    if (ph_acc < 0) begin
      ph_acc = ph_acc + int'(rate_cfg);
      if (!need_read || ph_acc < 0) begin
        need_read = 1'b1;
        return 1'b0;
      end
    end
    need_read = 1'b0;
    w_old = longint'(ph_acc / 256);
    w_new = longint'((SRC_RATE - ph_acc) / 256);
    acc = (longint'(prev_smp) * w_old + longint'(last_smp) * w_new) / longint'(SRC_RATE / 256);
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    y = sample_t'(acc);
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input sample_t want, input sample_t got);
    if (mismatches < 10)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  // Predict on each input beat, check each output beat in order
  always @(posedge clk) begin : sample_check
    sample_t y;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        if (resample(source_sample, y)) due_samples.push_back(y);
      end
      if (out_valid && !out_stall) begin
        if (due_samples.size() == 0) begin
          report_mismatch("unexpected output beat", '0, out_sample);
        end else begin
          y = due_samples.pop_front();
          if (out_sample !== y) report_mismatch("out_sample", y, out_sample);
        end
      end
    end
  end

  // End the run after a long stretch with no beat on any channel
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Output stall: long hold on request, random bursts, none while quiet
  always @(negedge clk) begin : out_stall_driver
    logic nxt;
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      nxt = 1'b1;
    end else if (quiet) begin
      nxt = 1'b0;
    end else if (busy_left > 0) begin
      busy_left--;
      nxt = 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      nxt = 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      busy_left = $urandom_range(0, 9);
      nxt = 1'b1;
    end else begin
      free_left = $urandom_range(0, 20);
      nxt = 1'b0;
    end
    out_stall <= nxt;
  end

  // Drop valid and idle the sender; n sets the length of the gap
  task automatic sender_gap(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Offer one sample and hold it until accepted
  task automatic send_sample(input sample_t s);
    if (!quiet && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 10));
    @(negedge clk);
    in_valid <= 1'b1;
    source_sample <= s;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return sample_t'($urandom_range(0, 3) - 2);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Stop offering, wait for every result, then let items with no result settle
  task automatic wait_idle();
    sender_gap(1);
    while (due_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_rate(input rate_t r);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= r;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    rate_cfg = r;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Extremes at the reset rate, where the pending read first shows up
  task automatic test_reset_rate();
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shffff);
    send_sample(16'sh0001);
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
  endtask

  // Equal and top rates pass samples straight through
  task automatic test_passthrough();
    write_rate(rate_t'(SRC_RATE));
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    write_rate(18'h3ffff);
    send_sample(16'shffff);
    send_sample(16'sh5555);
  endtask

  // Zero rate never yields; then a rate change while a read is pending
  task automatic test_zero_rate();
    write_rate('0);
    send_sample(16'sh1234);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    write_rate(rate_t'(SRC_RATE - 1));
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'shaaaa);
    send_sample(16'sh0001);
  endtask

  // Rate of one: phase is only nudged up, no output in a short run
  task automatic test_low_rate();
    write_rate(18'd1);
    send_sample(16'sh4000);
    send_sample(16'shc000);
    send_sample(16'sh7fff);
  endtask

  // Hold the output long enough that the block fills and stalls its input
  task automatic test_backpressure();
    write_rate(18'h3ffff);
    hold_req = 1'b1;
    repeat (24) send_sample(pick_sample());
  endtask

  // Pause the sender until every result is back, then carry on
  task automatic test_drain();
    write_rate(18'd44100);
    repeat (12) send_sample(pick_sample());
    wait_idle();
    repeat (12) send_sample(pick_sample());
  endtask

  // Phases of random rates with random samples
  task automatic test_random_rates();
    rate_t r;
    int n;
    for (int p = 0; p < 12; p++) begin
      n = 30;
      case ($urandom_range(0, 7))
        0: r = rate_t'(SRC_RATE - 1);
        1: r = rate_t'($urandom_range(SRC_RATE, 262143));
        2: r = 18'h3ffff;
        3: begin
          r = rate_t'($urandom_range(0, 2000));
          n = 6;
        end
        default: r = rate_t'($urandom_range(20000, SRC_RATE - 1));
      endcase
      write_rate(r);
      repeat (n) send_sample(pick_sample());
    end
  endtask

  // Back-to-back beats with no idling on either side
  task automatic test_steady_stream();
    write_rate(rate_t'($urandom_range(30000, SRC_RATE - 1)));
    quiet = 1'b1;
    repeat (40) send_sample(pick_sample());
  endtask

  initial begin : main
    rate_cfg = TARGET_RESET;
    ph_acc = 0;
    prev_smp = 0;
    last_smp = 0;
    need_read = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    test_reset_rate();
    test_passthrough();
    test_zero_rate();
    test_low_rate();
    test_backpressure();
    test_drain();
    test_random_rates();
    test_steady_stream();
    wait_idle();
    if (mismatches == 0 && due_samples.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/lid_pkg.sv
hdl/linear_interp_downsampler.sv
hdl/lid_checker.sv
dv/linear_interp_downsampler_test.sv
